/* rtl/oxd_pkg.sv */
// Shared types, widths and constants for the omni X-drive wheel speed pipeline.
// No dependencies.
`default_nettype none
package oxd_pkg;

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] side;
    logic [15:0] rate;
  } cmd_t;

  localparam logic [1:0] CFG_INV_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_CENTER_DIST = 2'd1;

  localparam logic [15:0] INV_RADIUS_RST  = 16'd5120;
  localparam logic [15:0] CENTER_DIST_RST = 16'd6554;

  localparam int XW      = 34;
  localparam int CS_W    = 18;
  localparam int PROD_W  = 34;
  localparam int BODY_W  = 35;
  localparam int LIN_W   = 36;
  localparam int SPIN_W  = 33;
  localparam int MIX_W   = 53;
  localparam int TOT_W   = 54;
  localparam int VEL_W   = 38;
  localparam int SCL_W   = 55;
  localparam int RND_W   = 56;
  localparam int Q_W     = 32;
  localparam int SPD_W   = 24;

  localparam logic signed [XW-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic signed [16:0] HALF_SQRT2_Q16 = 17'sd46341;
  localparam logic signed [Q_W-1:0] SPEED_MAX = 32'sd8388607;
  localparam logic signed [Q_W-1:0] SPEED_MIN = -32'sd8388608;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_lut(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* rtl/oxd_sincos.sv */
// Pipelined rotation-mode CORDIC: cosine and sine of a binary angle, Q.16.
// Carries the command payload alongside. Depends on oxd_pkg.
`default_nettype none
module oxd_sincos #(
  parameter int ANGLE_BITS  = 16,
  parameter int SINE_STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_vld,
  input  wire oxd_pkg::cmd_t                     in_cmd,
  input  wire logic [15:0]                       in_heading,
  output logic                                   out_vld,
  output oxd_pkg::cmd_t                          out_cmd,
  output logic signed [oxd_pkg::CS_W-1:0]        out_cos,
  output logic signed [oxd_pkg::CS_W-1:0]        out_sin
);
  import oxd_pkg::*;

  localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic signed [XW-1:0] x_r [0:SINE_STAGES];
  logic signed [XW-1:0] y_r [0:SINE_STAGES];
  logic signed [XW-1:0] z_r [0:SINE_STAGES];
  logic                 flip_r [0:SINE_STAGES];
  cmd_t                 cmd_r [0:SINE_STAGES];
  logic [SINE_STAGES:0] vld_r;

  logic [31:0] phase, phase_q, rot;
  logic        flip;

  assign phase   = {in_heading, 16'h0000} & KEEP;
  assign phase_q = phase + 32'h4000_0000;
  assign flip    = phase_q[31];
  assign rot     = flip ? (phase + 32'h8000_0000) : phase;

  always_ff @(posedge clk) begin
    x_r[0]    <= GAIN_INV_Q30;
    y_r[0]    <= '0;
    z_r[0]    <= XW'($signed(rot));
    flip_r[0] <= flip;
    cmd_r[0]  <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SINE_STAGES-1:0], in_vld};
    end
  end

  for (genvar i = 0; i < SINE_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy, ang;
    assign dx  = y_r[i] >>> i;
    assign dy  = x_r[i] >>> i;
    assign ang = $signed({2'b00, atan_lut(i)});

    always_ff @(posedge clk) begin
      if (!z_r[i][XW-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - ang;
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + ang;
      end
      flip_r[i+1] <= flip_r[i];
      cmd_r[i+1]  <= cmd_r[i];
    end
  end

  logic signed [XW-1:0] xf, yf;
  logic signed [XW:0]   xr, yr;
  logic                 out_vld_r;
  cmd_t                 out_cmd_r;
  logic signed [CS_W-1:0] cos_r, sin_r;

  assign xf = flip_r[SINE_STAGES] ? -x_r[SINE_STAGES] : x_r[SINE_STAGES];
  assign yf = flip_r[SINE_STAGES] ? -y_r[SINE_STAGES] : y_r[SINE_STAGES];
  assign xr = {xf[XW-1], xf} + (XW+1)'(8192);
  assign yr = {yf[XW-1], yf} + (XW+1)'(8192);

  always_ff @(posedge clk) begin
    cos_r     <= xr[CS_W+13:14];
    sin_r     <= yr[CS_W+13:14];
    out_cmd_r <= cmd_r[SINE_STAGES];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[SINE_STAGES];
    end
  end

  assign out_vld = out_vld_r;
  assign out_cmd = out_cmd_r;
  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule
`default_nettype wire

/* rtl/omni_x_drive_wheel_speeds.sv */
// Omni X-drive inverse kinematics: world velocity and heading in, four wheel speeds out.
// Accepts one command per cycle; busy never asserts. Results cannot be stalled.
// Synchronous active-low reset clears valid bits and restores both config registers.
// Depends on oxd_pkg and oxd_sincos.
`default_nettype none
module omni_x_drive_wheel_speeds #(
  parameter int ANGLE_BITS  = 16,
  parameter int SINE_STAGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [15:0]             in_forward_velocity,
  input  wire logic signed [15:0]             in_side_velocity,
  input  wire logic signed [15:0]             in_yaw_rate,
  input  wire logic [15:0]                    in_heading,
  output logic                                out_valid,
  output logic signed [oxd_pkg::SPD_W-1:0]    out_wheel_one_speed,
  output logic signed [oxd_pkg::SPD_W-1:0]    out_wheel_two_speed,
  output logic signed [oxd_pkg::SPD_W-1:0]    out_wheel_three_speed,
  output logic signed [oxd_pkg::SPD_W-1:0]    out_wheel_four_speed,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [15:0]                    cfg_data
);
  import oxd_pkg::*;

  logic [15:0] inv_radius_r, center_dist_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_radius_r  <= INV_RADIUS_RST;
      center_dist_r <= CENTER_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_INV_RADIUS) inv_radius_r <= cfg_data;
      if (cfg_index == CFG_CENTER_DIST) center_dist_r <= cfg_data;
    end
  end

  cmd_t in_cmd, sc_cmd;
  logic sc_vld;
  logic signed [CS_W-1:0] sc_cos, sc_sin;

  assign in_cmd.fwd  = in_forward_velocity;
  assign in_cmd.side = in_side_velocity;
  assign in_cmd.rate = in_yaw_rate;

  oxd_sincos #(
    .ANGLE_BITS  (ANGLE_BITS),
    .SINE_STAGES (SINE_STAGES)
  ) u_sincos (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (start && !busy),
    .in_cmd     (in_cmd),
    .in_heading (in_heading),
    .out_vld    (sc_vld),
    .out_cmd    (sc_cmd),
    .out_cos    (sc_cos),
    .out_sin    (sc_sin)
  );

  logic [6:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], sc_vld};
    end
  end

  // products
  logic signed [PROD_W-1:0] fc_r, ss_r, scv_r, fs_r;
  logic signed [PROD_W-1:0] fc_nxt, ss_nxt, scv_nxt, fs_nxt;
  logic signed [SPIN_W-1:0] spin1_r, spin2_r, spin3_r, spin4_r, spin_nxt;
  logic signed [15:0] fwd_s, side_s, rate_s;
  logic signed [16:0] cd_s, ir_s;

  assign fwd_s   = $signed(sc_cmd.fwd);
  assign side_s  = $signed(sc_cmd.side);
  assign rate_s  = $signed(sc_cmd.rate);
  assign cd_s    = $signed({1'b0, center_dist_r});
  assign ir_s    = $signed({1'b0, inv_radius_r});
  assign fc_nxt  = fwd_s * sc_cos;
  assign ss_nxt  = side_s * sc_sin;
  assign scv_nxt = side_s * sc_cos;
  assign fs_nxt  = fwd_s * sc_sin;
  assign spin_nxt = cd_s * rate_s;

  always_ff @(posedge clk) begin
    fc_r    <= fc_nxt;
    ss_r    <= ss_nxt;
    scv_r   <= scv_nxt;
    fs_r    <= fs_nxt;
    spin1_r <= spin_nxt;
  end

  // body frame velocities
  logic signed [BODY_W-1:0] bf_r, bs_r;

  always_ff @(posedge clk) begin
    bf_r    <= BODY_W'(fc_r) + BODY_W'(ss_r);
    bs_r    <= BODY_W'(scv_r) - BODY_W'(fs_r);
    spin2_r <= spin1_r;
  end

  // per-wheel linear terms: signs (-,+) (-,-) (+,-) (+,+)
  logic signed [LIN_W-1:0] lin_r [0:3];
  logic signed [LIN_W-1:0] bf_x, bs_x;

  assign bf_x = LIN_W'(bf_r);
  assign bs_x = LIN_W'(bs_r);

  always_ff @(posedge clk) begin
    lin_r[0] <= bs_x - bf_x;
    lin_r[1] <= -bf_x - bs_x;
    lin_r[2] <= bf_x - bs_x;
    lin_r[3] <= bf_x + bs_x;
    spin3_r  <= spin2_r;
  end

  logic signed [MIX_W-1:0] mix_r [0:3];
  logic signed [VEL_W-1:0] vel_r [0:3];
  logic signed [SCL_W-1:0] scl_r [0:3];
  logic signed [SPD_W-1:0] spd_r [0:3];
  logic signed [TOT_W-1:0] spin_q40;

  always_ff @(posedge clk) begin
    spin4_r <= spin3_r;
  end

  assign spin_q40 = {{(TOT_W-SPIN_W-16){spin4_r[SPIN_W-1]}}, spin4_r, 16'h0000};

  for (genvar k = 0; k < 4; k++) begin : g_wheel
    logic signed [MIX_W-1:0] mix_nxt;
    logic signed [TOT_W-1:0] tot;
    logic signed [SCL_W-1:0] scl_nxt;
    logic signed [RND_W-1:0] rnd;
    logic signed [Q_W-1:0]   q;

    assign mix_nxt = lin_r[k] * HALF_SQRT2_Q16;
    assign tot     = TOT_W'(mix_r[k]) + spin_q40 + TOT_W'(32768);
    assign scl_nxt = vel_r[k] * ir_s;
    assign rnd     = RND_W'(scl_r[k]) + RND_W'(8388608);
    assign q       = rnd[RND_W-1:24];

    always_ff @(posedge clk) begin
      mix_r[k] <= mix_nxt;
      vel_r[k] <= tot[TOT_W-1:16];
      scl_r[k] <= scl_nxt;
      if (q > SPEED_MAX) begin
        spd_r[k] <= SPD_W'(SPEED_MAX);
      end else if (q < SPEED_MIN) begin
        spd_r[k] <= SPD_W'(SPEED_MIN);
      end else begin
        spd_r[k] <= q[SPD_W-1:0];
      end
    end
  end

  assign out_valid             = vld_r[6];
  assign out_wheel_one_speed   = spd_r[0];
  assign out_wheel_two_speed   = spd_r[1];
  assign out_wheel_three_speed = spd_r[2];
  assign out_wheel_four_speed  = spd_r[3];

endmodule
`default_nettype wire
